@@ src/qrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_pkg
// Shared constants and types for the quaternion point rotator.
// ----------------------------------------------------------------------------
package qrp_pkg;

	// quaternion component format: signed, 16 bits
	localparam int QUAT_W = 16;

	// defaults for the top-level parameters
	localparam int COORD_WIDTH_DEF    = 32;
	localparam int COEF_FRAC_BITS_DEF = 14;

	// width of an unrounded matrix term: sums of two doubled 16x16 products,
	// plus headroom for the rounding offset
	localparam int FULL_W = 35;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

	// reset values of the components (identity rotation, 1.0 in Q2.14)
	localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = 16'sd16384;
	localparam logic signed [QUAT_W-1:0] QUAT_V_RESET = 16'sd0;

	// cycles the matrix needs after a component changes
	localparam logic [1:0] REBUILD_CYCLES = 2'd2;

	// per-stage advance strobes of the point pipeline
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} qrp_adv_t;

endpackage

@@ src/qrp_point_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_point_if
// Point request channel: valid/ready with three signed coordinates.
// ----------------------------------------------------------------------------
interface qrp_point_if #(
	parameter int COORD_WIDTH = qrp_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

@@ src/qrp_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_result_if
// Rotated point channel: valid/ready, three coordinates and a clamp flag.
// ----------------------------------------------------------------------------
interface qrp_result_if #(
	parameter int COORD_WIDTH = qrp_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rotated_x;
	logic signed [COORD_WIDTH-1:0] rotated_y;
	logic signed [COORD_WIDTH-1:0] rotated_z;
	logic                          saturated;

	modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
		output saturated, input ready);
	modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
		input saturated, output ready);
endinterface

@@ src/qrp_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_matrix
// Forms the nine rotation matrix terms from the quaternion in two stages:
// products, then sums with round-half-up to COEF_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module qrp_matrix #(
	parameter int COEF_FRAC_BITS = qrp_pkg::COEF_FRAC_BITS_DEF,
	localparam int MT_W = qrp_pkg::FULL_W - COEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic signed [qrp_pkg::QUAT_W-1:0] qw,
	input  logic signed [qrp_pkg::QUAT_W-1:0] qx,
	input  logic signed [qrp_pkg::QUAT_W-1:0] qy,
	input  logic signed [qrp_pkg::QUAT_W-1:0] qz,
	output logic signed [MT_W-1:0]           term [9]
);
	import qrp_pkg::*;

	localparam int PW = 2 * QUAT_W;
	localparam logic signed [FULL_W-1:0] HALF = FULL_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [PW-1:0] w2_q, x2_q, y2_q, z2_q;
	logic signed [PW-1:0] xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	logic signed [FULL_W-1:0] full [9];
	logic signed [FULL_W-1:0] rnd  [9];

	always_ff @(posedge clk) begin
		w2_q <= qw * qw;
		x2_q <= qx * qx;
		y2_q <= qy * qy;
		z2_q <= qz * qz;
		xy_q <= qx * qy;
		xz_q <= qx * qz;
		yz_q <= qy * qz;
		wx_q <= qw * qx;
		wy_q <= qw * qy;
		wz_q <= qw * qz;
	end

	always_comb begin
		full[0] = FULL_W'(w2_q) + FULL_W'(x2_q) - FULL_W'(y2_q) - FULL_W'(z2_q);
		full[1] = (FULL_W'(xy_q) <<< 1) - (FULL_W'(wz_q) <<< 1);
		full[2] = (FULL_W'(xz_q) <<< 1) + (FULL_W'(wy_q) <<< 1);
		full[3] = (FULL_W'(xy_q) <<< 1) + (FULL_W'(wz_q) <<< 1);
		full[4] = FULL_W'(w2_q) - FULL_W'(x2_q) + FULL_W'(y2_q) - FULL_W'(z2_q);
		full[5] = (FULL_W'(yz_q) <<< 1) - (FULL_W'(wx_q) <<< 1);
		full[6] = (FULL_W'(xz_q) <<< 1) - (FULL_W'(wy_q) <<< 1);
		full[7] = (FULL_W'(yz_q) <<< 1) + (FULL_W'(wx_q) <<< 1);
		full[8] = FULL_W'(w2_q) - FULL_W'(x2_q) - FULL_W'(y2_q) + FULL_W'(z2_q);
		for (int i = 0; i < 9; i++) begin
			rnd[i] = full[i] + HALF;
		end
	end

	// floor after the half-LSB offset: drop the low fraction bits
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			term[i] <= rnd[i][FULL_W-1:COEF_FRAC_BITS];
		end
	end

endmodule

@@ src/qrp_row.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_row
// One output coordinate: three products, rounded sum, clamp to COORD_WIDTH.
// ----------------------------------------------------------------------------
module qrp_row #(
	parameter int COORD_WIDTH    = qrp_pkg::COORD_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = qrp_pkg::COEF_FRAC_BITS_DEF,
	localparam int MT_W = qrp_pkg::FULL_W - COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  qrp_pkg::qrp_adv_t             adv,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  logic signed [MT_W-1:0]        m0,
	input  logic signed [MT_W-1:0]        m1,
	input  logic signed [MT_W-1:0]        m2,
	output logic signed [COORD_WIDTH-1:0] rot,
	output logic                          sat
);
	import qrp_pkg::*;

	localparam int PROD_W = MT_W + COORD_WIDTH;
	localparam int SUM_A  = PROD_W + 2;
	localparam int SUM_B  = COORD_WIDTH + COEF_FRAC_BITS + 1;
	localparam int SUM_W  = (SUM_A > SUM_B) ? SUM_A : SUM_B;
	localparam int RND_W  = SUM_W - COEF_FRAC_BITS;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [SUM_W-1:0]  sum;
	logic signed [RND_W-1:0]  rnd_s2;
	logic [RND_W-COORD_WIDTH:0] top_bits;
	logic                     in_range;

	always_ff @(posedge clk) begin
		if (adv.en1) begin
			p0_s1 <= m0 * px;
			p1_s1 <= m1 * py;
			p2_s1 <= m2 * pz;
		end
	end

	assign sum = SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1) + HALF;

	always_ff @(posedge clk) begin
		if (adv.en2) begin
			rnd_s2 <= sum[SUM_W-1:COEF_FRAC_BITS];
		end
	end

	// fits when the bits above the output sign bit all match it
	assign top_bits = rnd_s2[RND_W-1:COORD_WIDTH-1];
	assign in_range = (&top_bits) | ~(|top_bits);

	always_ff @(posedge clk) begin
		if (adv.en3) begin
			sat <= ~in_range;
			if (in_range) begin
				rot <= rnd_s2[COORD_WIDTH-1:0];
			end else if (rnd_s2[RND_W-1]) begin
				rot <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				rot <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
		end
	end

endmodule

@@ src/quaternion_rotate_point.sv @@
`timescale 1ns / 1ps
// Pipeline: accepted points pass multiply, sum+round and clamp registers to result valid.
// Throughput: one point per cycle while results are taken and no rebuild runs; the nine
//   coefficient-by-coordinate multipliers take a new point every cycle, a stalled result
//   freezes only full stages. Reset (arst_n low) restores the identity quaternion; the
//   matrix is then rebuilt, so point.ready stays low after reset and after any cfg write.
// ----------------------------------------------------------------------------
// quaternion_rotate_point
// Rotates a stream of Q16.16 points by a configured Q2.14 unit quaternion,
// saturating results and flagging any clamp.
// ----------------------------------------------------------------------------
module quaternion_rotate_point #(
	parameter int COORD_WIDTH    = qrp_pkg::COORD_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = qrp_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qrp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qrp_pkg::QUAT_W-1:0]          cfg_data,
	qrp_point_if.sink                           point,
	qrp_result_if.source                        result
);
	import qrp_pkg::*;

	localparam int MT_W = FULL_W - COEF_FRAC_BITS;

	// quaternion components, Q2.14
	logic signed [QUAT_W-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;

	// countdown while the matrix terms catch up with the components
	logic [1:0] rebuild_q;

	logic signed [MT_W-1:0] term [9];

	// pipeline occupancy
	logic v_s1, v_s2, v_s3;
	qrp_adv_t adv;
	logic     in_acc;

	logic sat_x, sat_y, sat_z;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q <= QUAT_W_RESET;
			quat_x_q <= QUAT_V_RESET;
			quat_y_q <= QUAT_V_RESET;
			quat_z_q <= QUAT_V_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUAT_W: quat_w_q <= cfg_data;
				REG_QUAT_X: quat_x_q <= cfg_data;
				REG_QUAT_Y: quat_y_q <= cfg_data;
				REG_QUAT_Z: quat_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// starts loaded so that the reset quaternion is turned into terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rebuild_q <= REBUILD_CYCLES;
		end else if (cfg_we) begin
			rebuild_q <= REBUILD_CYCLES;
		end else if (rebuild_q != 2'd0) begin
			rebuild_q <= rebuild_q - 2'd1;
		end
	end

	// two-stage term build: products, then sums rounded to coefficient format
	qrp_matrix #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_matrix (
		.clk (clk),
		.qw  (quat_w_q),
		.qx  (quat_x_q),
		.qy  (quat_y_q),
		.qz  (quat_z_q),
		.term(term)
	);

	// -------------------------------------------------------------- pipeline
	// A stage advances when it is empty or the stage after it advances, so
	// bubbles close up behind a stalled result.
	always_comb begin
		adv.en3 = !v_s3 || result.ready;
		adv.en2 = !v_s2 || adv.en3;
		adv.en1 = !v_s1 || adv.en2;
	end

	assign point.ready = adv.en1 && (rebuild_q == 2'd0);
	assign in_acc      = point.valid && point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv.en1) begin
				v_s1 <= in_acc;
			end
			if (adv.en2) begin
				v_s2 <= v_s1;
			end
			if (adv.en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// one row of the matrix per output coordinate
	qrp_row #(
		.COORD_WIDTH   (COORD_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_row_x (
		.clk(clk), .adv(adv),
		.px(point.point_x), .py(point.point_y), .pz(point.point_z),
		.m0(term[0]), .m1(term[1]), .m2(term[2]),
		.rot(result.rotated_x), .sat(sat_x)
	);

	qrp_row #(
		.COORD_WIDTH   (COORD_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_row_y (
		.clk(clk), .adv(adv),
		.px(point.point_x), .py(point.point_y), .pz(point.point_z),
		.m0(term[3]), .m1(term[4]), .m2(term[5]),
		.rot(result.rotated_y), .sat(sat_y)
	);

	qrp_row #(
		.COORD_WIDTH   (COORD_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_row_z (
		.clk(clk), .adv(adv),
		.px(point.point_x), .py(point.point_y), .pz(point.point_z),
		.m0(term[6]), .m1(term[7]), .m2(term[8]),
		.rot(result.rotated_z), .sat(sat_z)
	);

	assign result.valid     = v_s3;
	assign result.saturated = sat_x | sat_y | sat_z;

endmodule

@@ src/qrp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_checker
// Port-level checks for the quaternion point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module qrp_checker #(
	parameter int COORD_WIDTH = qrp_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] rx,
	input logic signed [COORD_WIDTH-1:0] ry,
	input logic signed [COORD_WIDTH-1:0] rz,
	input logic                          sat
);
	import qrp_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// requests accepted but not yet delivered
	logic [2:0] occ_q;
	logic       acc_in, acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 3'd0;
		end else if (acc_in && !acc_out) begin
			occ_q <= occ_q + 3'd1;
		end else if (acc_out && !acc_in) begin
			occ_q <= occ_q - 3'd1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != 3'd0))
		else $error("result without an outstanding request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'd3)
		else $error("more requests in flight than pipeline stages");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("request taken while matrix is rebuilding");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sat) |-> (rx == MAXV || rx == MINV || ry == MAXV || ry == MINV
			|| rz == MAXV || rz == MINV))
		else $error("saturated flag without a clamped coordinate");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(rx) && $stable(ry)
			&& $stable(rz) && $stable(sat)))
		else $error("stalled result changed");

endmodule

bind quaternion_rotate_point qrp_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_qrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.in_valid (point.valid),
	.in_ready (point.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.rx       (result.rotated_x),
	.ry       (result.rotated_y),
	.rz       (result.rotated_z),
	.sat      (result.saturated)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_rotate_point. A fixed-point model of the
// rotation predicts every rotated point; results are checked in order while
// the quaternion and the idling pattern change from phase to phase.
// ----------------------------------------------------------------------------
module tb;
	import qrp_pkg::*;

	localparam int CW         = COORD_WIDTH_DEF;
	localparam int FRAC       = COEF_FRAC_BITS_DEF;
	localparam int CYCLE_CAP  = 200000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_PTS  = 62;
	localparam int LONG_HOLD  = 300;
	localparam int MAX_REPORT = 40;

	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] C_ONE = 1 <<< 16;  // 1.0 in Q16.16

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
		logic signed [CW-1:0] rz;
		logic                 sat;
	} rotated_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [QUAT_W-1:0]    cfg_data;

	qrp_point_if  #(.COORD_WIDTH(CW)) point_ch ();
	qrp_result_if #(.COORD_WIDTH(CW)) result_ch ();

	quaternion_rotate_point #(
		.COORD_WIDTH   (CW),
		.COEF_FRAC_BITS(FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.point    (point_ch),
		.result   (result_ch)
	);

	// model copy of the quaternion and the rounded matrix built from it
	logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;
	longint                   rot_m [9];

	point_t   pending_points [$];   // requests not yet accepted, head is on the bus
	rotated_t expected_rot   [$];   // predicted results, oldest first

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_req = 0;              // long receiver hold-off, picked up by the receiver
	int  hold_left = 0;
	bit  point_taken = 1'b0;
	int  err_cnt = 0;
	int  accepted_cnt = 0;
	int  checked_cnt = 0;
	int  sat_cnt = 0;
	int  settings_cnt = 1;
	int  cycle_cnt = 0;

	// ------------------------------------------------------------------------
	// fixed-point model
	// ------------------------------------------------------------------------

	// add half an LSB, then floor (arithmetic shift of a signed longint)
	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// nine matrix terms from squares and pairwise products, cross terms doubled
	function automatic void build_rotation();
		longint w, x, y, z;
		longint full [9];
		w = longint'(q_w);
		x = longint'(q_x);
		y = longint'(q_y);
		z = longint'(q_z);
		full[0] = w*w + x*x - y*y - z*z;
		full[1] = 2*x*y - 2*w*z;
		full[2] = 2*x*z + 2*w*y;
		full[3] = 2*x*y + 2*w*z;
		full[4] = w*w - x*x + y*y - z*z;
		full[5] = 2*y*z - 2*w*x;
		full[6] = 2*x*z - 2*w*y;
		full[7] = 2*y*z + 2*w*x;
		full[8] = w*w - x*x - y*y + z*z;
		for (int i = 0; i < 9; i++)
			rot_m[i] = round_half_up(full[i], FRAC);
	endfunction

	// matrix times point, rounded back to Q16.16, clamped to the coordinate range
	function automatic rotated_t rotate_point(input point_t p);
		longint               pv [3];
		longint               acc, v;
		longint               hi, lo;
		logic signed [CW-1:0] outv [3];
		rotated_t             r;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		pv[0] = longint'(p.x);
		pv[1] = longint'(p.y);
		pv[2] = longint'(p.z);
		r.sat = 1'b0;
		for (int row = 0; row < 3; row++) begin
			acc = rot_m[row*3] * pv[0] + rot_m[row*3+1] * pv[1] + rot_m[row*3+2] * pv[2];
			v = round_half_up(acc, FRAC);
			if (v > hi) begin
				v = hi;
				r.sat = 1'b1;
			end
			if (v < lo) begin
				v = lo;
				r.sat = 1'b1;
			end
			outv[row] = v[CW-1:0];
		end
		r.rx = outv[0];
		r.ry = outv[1];
		r.rz = outv[2];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// clock and cycle cap
	// ------------------------------------------------------------------------
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_cnt, expected_rot.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// point driver
	// ------------------------------------------------------------------------
	// Acceptance is seen at the rising edge: the head request leaves the queue
	// and its prediction is queued. The matrix only changes while nothing is in
	// flight, so predicting here is exact.
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready) begin
			expected_rot.push_back(rotate_point(pending_points[0]));
			pending_points.pop_front();
			point_taken = 1'b1;
			accepted_cnt++;
		end
	end

	// New request or gap at the falling edge; an offered request holds until taken.
	always @(negedge clk) begin
		if (!point_ch.valid || point_taken) begin
			point_taken = 1'b0;
			if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				point_ch.valid   <= 1'b1;
				point_ch.point_x <= pending_points[0].x;
				point_ch.point_y <= pending_points[0].y;
				point_ch.point_z <= pending_points[0].z;
			end else begin
				point_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result receiver: random stalls, plus a long hold-off on request so the
	// pipeline fills and pushes back on the point channel
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// monitor: every accepted result against the oldest prediction
	// ------------------------------------------------------------------------
	task automatic check_field(input string fname, input logic [CW-1:0] exp_v,
		input logic [CW-1:0] act_v);
		if (exp_v !== act_v) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORT)
				$display("%0t: %s mismatch, expected %h got %h", $time, fname, exp_v, act_v);
			else if (err_cnt == MAX_REPORT + 1)
				$display("%0t: further mismatches not shown", $time);
		end
	endtask

	always @(posedge clk) begin
		rotated_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_rot.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result, expected none got %h %h %h sat %b", $time,
					result_ch.rotated_x, result_ch.rotated_y, result_ch.rotated_z,
					result_ch.saturated);
			end else begin
				e = expected_rot.pop_front();
				checked_cnt++;
				if (e.sat)
					sat_cnt++;
				check_field("rotated_x", e.rx, result_ch.rotated_x);
				check_field("rotated_y", e.ry, result_ch.rotated_y);
				check_field("rotated_z", e.rz, result_ch.rotated_z);
				check_field("saturated", CW'(e.sat), CW'(result_ch.saturated));
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic void push_point(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
		pending_points.push_back('{x: x, y: y, z: z});
	endfunction

	function automatic logic signed [CW-1:0] rand_coord(input int kind);
		logic signed [CW-1:0] edges [5];
		edges = '{C_MAX, C_MIN, '0, -1, 1};
		case (kind)
			0: return $urandom;                                    // full range
			1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);  // about +-16.0
			default: return edges[$urandom_range(0, 4)];
		endcase
	endfunction

	// mostly full-range points, some small ones that stay clear of the clamp,
	// a few built from the edges of the range
	function automatic void push_random_point();
		int kind;
		kind = $urandom_range(0, 9);
		kind = (kind < 6) ? 0 : (kind < 9) ? 1 : 2;
		push_point(rand_coord(kind), rand_coord(kind), rand_coord(kind));
	endfunction

	function automatic logic signed [QUAT_W-1:0] rand_comp();
		if ($urandom_range(0, 1))
			return QUAT_W'($urandom);
		return QUAT_W'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic void set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct  = 49;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 49;
			end
			default: begin
				send_idle_pct  = 15;
				recv_stall_pct = 15;
			end
		endcase
	endfunction

	// write all four components back to back; called only with the block idle
	task automatic write_quat(input logic signed [QUAT_W-1:0] w,
		input logic signed [QUAT_W-1:0] x, input logic signed [QUAT_W-1:0] y,
		input logic signed [QUAT_W-1:0] z);
		logic [QUAT_W-1:0]    vals [4];
		logic [CFG_IDX_W-1:0] idx  [4];
		vals = '{w, x, y, z};
		idx  = '{REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		q_w = w;
		q_x = x;
		q_y = y;
		q_z = z;
		build_rotation();
		settings_cnt++;
		@(posedge clk);
	endtask

	// until every request is taken and every prediction is matched
	task automatic drain();
		while (pending_points.size() > 0 || expected_rot.size() > 0)
			@(posedge clk);
	endtask

	// directed points: range edges, unit vectors, mixed signs
	function automatic void push_directed_points();
		push_point('0, '0, '0);
		push_point(C_MAX, C_MAX, C_MAX);
		push_point(C_MIN, C_MIN, C_MIN);
		push_point(C_MAX, C_MIN, '0);
		push_point(C_MIN, C_MAX, -1);
		push_point(1, -1, 1);
		push_point(-1, -1, -1);
		push_point(C_ONE, '0, '0);
		push_point('0, C_ONE, '0);
		push_point('0, '0, C_ONE);
		push_point(C_MAX, C_MAX, C_MIN);
		push_point(32'sh1234_5678, -32'sh2468_ace0, 32'sh0f0f_0f0f);
	endfunction

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		idle_mode_t mode;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_QUAT_W;
		cfg_data           = '0;
		point_ch.valid     = 1'b0;
		point_ch.point_x   = '0;
		point_ch.point_y   = '0;
		point_ch.point_z   = '0;
		result_ch.ready    = 1'b0;
		q_w = QUAT_W_RESET;
		q_x = QUAT_V_RESET;
		q_y = QUAT_V_RESET;
		q_z = QUAT_V_RESET;
		build_rotation();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset quaternion is the identity: points must come back unchanged
		set_idling(IDLE_NONE);
		push_directed_points();
		drain();

		// 90 degrees about z: the edges of the range now overflow and clamp
		write_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
		push_directed_points();
		drain();

		// random phases: extreme and non-unit quaternions and a half turn first, then
		// random ones, cycling through the idling patterns
		for (int p = 0; p < RAND_PHASES; p++) begin
			mode = idle_mode_t'(p % 4);
			set_idling(mode);
			case (p)
				0: write_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
				1: write_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
				2: write_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
				3: write_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);  // 180 degrees about x
				default: write_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
			endcase
			// long receiver hold-off while the sender keeps offering
			if (p == 4)
				hold_req = LONG_HOLD;
			for (int n = 0; n < PHASE_PTS; n++)
				push_random_point();
			drain();
		end

		// look for stray results after the last prediction is matched
		repeat (10) @(posedge clk);

		$display("Rotated %0d points under %0d quaternion settings, %0d of them clamped.",
			checked_cnt, settings_cnt, sat_cnt);
		$display("Idling patterns: none, sender gaps, receiver stalls, both, and a %0d-cycle hold.",
			LONG_HOLD);
		if (err_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/qrp_pkg.sv
src/qrp_point_if.sv
src/qrp_result_if.sv
src/qrp_matrix.sv
src/qrp_row.sv
src/quaternion_rotate_point.sv
src/qrp_checker.sv
tb/sv/tb.sv
